// ----- hw/rtl/http_request_head_parser_top_defines.svh -----
// assertion macros for the http request head parser
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HRHP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define HRHP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/hrhp_pkg.sv -----
// types and constants of the http request head parser
package hrhp_pkg;

  typedef enum logic [4:0] {
    ST_READY    = 5'd0,
    ST_METHOD   = 5'd1,
    ST_SPACES   = 5'd2,
    ST_URI      = 5'd3,
    ST_ARGS     = 5'd4,
    ST_ARGVAL   = 5'd5,
    ST_PROT     = 5'd6,
    ST_P_H      = 5'd7,
    ST_P_HT     = 5'd8,
    ST_P_HTT    = 5'd9,
    ST_P_HTTP   = 5'd10,
    ST_MAJOR    = 5'd11,
    ST_MINOR    = 5'd12,
    ST_PFINAL   = 5'd13,
    ST_LAST     = 5'd14,
    ST_HFIRST   = 5'd15,
    ST_HREADY   = 5'd16,
    ST_HKEY     = 5'd17,
    ST_HVBEGIN  = 5'd18,
    ST_HVAL     = 5'd19,
    ST_HVSPACE  = 5'd20,
    ST_HVFINAL  = 5'd21,
    ST_BLOCKEND = 5'd22
  } state_t;

  typedef enum logic [1:0] {
    STAT_MORE    = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_BAD     = 2'd2,
    STAT_NOT_ALW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE   = 2'd0,
    PK_QUERY  = 2'd1,
    PK_HEADER = 2'd2
  } pair_kind_t;

  typedef enum logic [1:0] {
    METH_NONE = 2'd0,
    METH_GET  = 2'd1,
    METH_HEAD = 2'd2,
    METH_POST = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    VER_09 = 2'd0,
    VER_10 = 2'd1,
    VER_11 = 2'd2
  } version_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam int TDATA_BITS = 136;

endpackage

// ----- hw/rtl/http_request_head_parser_top.sv -----
// http request head parser: byte stream in, one parse result per byte out
// each result passes the input register and then the result register; one byte per
// clock while m_tready allows it; the byte decode and every offset update sit in one
// short combinational step between the input register and the result register
// reset (rst, synchronous, active high) empties both registers, returns the parser
// to awaiting a method and clears status, method, version and all offsets
`include "http_request_head_parser_top_defines.svh"

module http_request_head_parser_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte [7:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [1:0], key_start [17:2], key_len [33:18], val_start [49:34],
  // val_len [65:50], method_code [67:66], version_code [69:68], uri_start [85:70],
  // uri_len [101:86], args_len [117:102], byte_offset [133:118], zero [135:134]
  output logic [hrhp_pkg::TDATA_BITS-1:0] m_tdata,
  output logic [1:0]                      m_tuser    // pair_kind [1:0]
);

  localparam int OW = OFFSET_BITS;
  typedef logic [OW-1:0] off_t;
  typedef logic [OW:0]   pos_t;   // one spare bit flags an offset overrun

  // low 16 bits of an offset, zero extended when offsets are narrower
  function automatic logic [15:0] o16(input off_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // ---------------------------------------------------------------- input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;   // the held byte is decoded and its result written this cycle

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // ---------------------------------------------------------------- parser state
  hrhp_pkg::state_t   state;
  hrhp_pkg::status_t  sticky;
  hrhp_pkg::method_t  method_q;
  hrhp_pkg::version_t version_q;
  pos_t position;
  off_t key_begin, key_end, value_begin, value_end;
  off_t uri_begin, uri_length, query_length;

  hrhp_pkg::state_t   state_next, state_fin;
  hrhp_pkg::status_t  err_code, stat_eff, stat_res, sticky_next;
  hrhp_pkg::method_t  method_next;
  hrhp_pkg::version_t version_next;
  hrhp_pkg::pair_kind_t emit_kind;
  pos_t position_next;
  off_t key_begin_next, key_end_next, value_begin_next, value_end_next;
  off_t uri_begin_next, uri_length_next, query_length_next;
  off_t pl, args_start, vend;
  off_t pks, pkl, pvs, pvl;
  logic eol, done, skip, emit_q;

  assign pl         = position[OW-1:0];
  assign args_start = off_t'(uri_begin + uri_length + 1'b1);

  // byte decode: next state and next values of the offset registers
  always_comb begin
    state_next        = state;
    err_code          = hrhp_pkg::STAT_MORE;
    done              = 1'b0;
    skip              = 1'b0;
    emit_kind         = hrhp_pkg::PK_NONE;
    emit_q            = 1'b0;
    method_next       = method_q;
    version_next      = version_q;
    key_begin_next    = key_begin;
    key_end_next      = key_end;
    value_begin_next  = value_begin;
    value_end_next    = value_end;
    uri_begin_next    = uri_begin;
    uri_length_next   = uri_length;
    query_length_next = query_length;
    eol = (in_byte == hrhp_pkg::CH_CR) || (in_byte == hrhp_pkg::CH_LF);

    if (sticky == hrhp_pkg::STAT_MORE && state == hrhp_pkg::ST_READY && eol) begin
      // blank lines ahead of a request are dropped
      skip = 1'b1;
    end else if (sticky == hrhp_pkg::STAT_MORE && position[OW]) begin
      err_code = hrhp_pkg::STAT_BAD;
    end else if (sticky == hrhp_pkg::STAT_MORE) begin
      unique case (state)
        hrhp_pkg::ST_READY: begin
          if (in_byte == hrhp_pkg::CH_G || in_byte == hrhp_pkg::CH_H ||
              in_byte == hrhp_pkg::CH_P) begin
            method_next = (in_byte == hrhp_pkg::CH_G) ? hrhp_pkg::METH_GET :
                          (in_byte == hrhp_pkg::CH_H) ? hrhp_pkg::METH_HEAD :
                                                        hrhp_pkg::METH_POST;
            version_next      = hrhp_pkg::VER_09;
            uri_begin_next    = '0;
            uri_length_next   = '0;
            query_length_next = '0;
            state_next        = hrhp_pkg::ST_METHOD;
          end else begin
            err_code = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_METHOD: begin
          if (in_byte == hrhp_pkg::CH_SP) state_next = hrhp_pkg::ST_SPACES;
        end
        hrhp_pkg::ST_SPACES: begin
          if (in_byte == hrhp_pkg::CH_SLASH) begin
            uri_begin_next = pl;
            state_next     = hrhp_pkg::ST_URI;
          end else if (in_byte != hrhp_pkg::CH_SP) begin
            err_code = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_URI, hrhp_pkg::ST_ARGS, hrhp_pkg::ST_ARGVAL: begin
          if (in_byte == hrhp_pkg::CH_SP || eol ||
              (state == hrhp_pkg::ST_URI && in_byte == hrhp_pkg::CH_QMARK)) begin
            if (state == hrhp_pkg::ST_URI) begin
              uri_length_next = off_t'(pl - uri_begin);
            end else begin
              if (state == hrhp_pkg::ST_ARGVAL) begin
                emit_kind = hrhp_pkg::PK_QUERY;
                emit_q    = 1'b1;
              end
              query_length_next = off_t'(pl - args_start);
            end
            if (in_byte == hrhp_pkg::CH_QMARK) begin
              key_begin_next = off_t'(pl + 1'b1);
              state_next     = hrhp_pkg::ST_ARGS;
            end else if (in_byte == hrhp_pkg::CH_SP) begin
              state_next = hrhp_pkg::ST_PROT;
            end else begin
              version_next = hrhp_pkg::VER_09;
              state_next   = (in_byte == hrhp_pkg::CH_CR) ? hrhp_pkg::ST_LAST :
                                                            hrhp_pkg::ST_HFIRST;
            end
          end else if (state != hrhp_pkg::ST_URI && in_byte == hrhp_pkg::CH_AMP) begin
            if (state == hrhp_pkg::ST_ARGVAL) begin
              emit_kind = hrhp_pkg::PK_QUERY;
              emit_q    = 1'b1;
            end
            key_begin_next = off_t'(pl + 1'b1);
            state_next     = hrhp_pkg::ST_ARGS;
          end else if (state == hrhp_pkg::ST_ARGS && in_byte == hrhp_pkg::CH_EQ) begin
            key_end_next     = pl;
            value_begin_next = off_t'(pl + 1'b1);
            state_next       = hrhp_pkg::ST_ARGVAL;
          end
        end
        hrhp_pkg::ST_PROT: begin
          if (in_byte == hrhp_pkg::CH_SP) begin
            state_next = state;
          end else if (eol) begin
            version_next = hrhp_pkg::VER_09;
            state_next   = (in_byte == hrhp_pkg::CH_CR) ? hrhp_pkg::ST_LAST :
                                                          hrhp_pkg::ST_HFIRST;
          end else if (in_byte == hrhp_pkg::CH_H) begin
            state_next = hrhp_pkg::ST_P_H;
          end else begin
            err_code = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_P_H: begin
          if (in_byte == hrhp_pkg::CH_T) state_next = hrhp_pkg::ST_P_HT;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HT: begin
          if (in_byte == hrhp_pkg::CH_T) state_next = hrhp_pkg::ST_P_HTT;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HTT: begin
          if (in_byte == hrhp_pkg::CH_P) state_next = hrhp_pkg::ST_P_HTTP;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HTTP: begin
          if (in_byte == hrhp_pkg::CH_SLASH) state_next = hrhp_pkg::ST_MAJOR;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_MAJOR: begin
          if (in_byte == hrhp_pkg::CH_DOT) state_next = hrhp_pkg::ST_MINOR;
          else if (in_byte == hrhp_pkg::CH_0) version_next = hrhp_pkg::VER_09;
          else if (in_byte == hrhp_pkg::CH_1) version_next = hrhp_pkg::VER_10;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_MINOR, hrhp_pkg::ST_PFINAL: begin
          if (in_byte == hrhp_pkg::CH_SP) state_next = hrhp_pkg::ST_PFINAL;
          else if (in_byte == hrhp_pkg::CH_CR) state_next = hrhp_pkg::ST_LAST;
          else if (in_byte == hrhp_pkg::CH_LF) state_next = hrhp_pkg::ST_HFIRST;
          else if (state == hrhp_pkg::ST_MINOR && in_byte == hrhp_pkg::CH_0)
            version_next = hrhp_pkg::VER_10;
          else if (state == hrhp_pkg::ST_MINOR && in_byte == hrhp_pkg::CH_1)
            version_next = hrhp_pkg::VER_11;
          else if (state == hrhp_pkg::ST_MINOR && in_byte == hrhp_pkg::CH_9)
            version_next = hrhp_pkg::VER_09;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_LAST: begin
          if (in_byte == hrhp_pkg::CH_LF) state_next = hrhp_pkg::ST_HFIRST;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_HFIRST, hrhp_pkg::ST_HREADY: begin
          // version 0.9 only allows get
          if (state == hrhp_pkg::ST_HFIRST && version_q == hrhp_pkg::VER_09 &&
              method_q != hrhp_pkg::METH_GET) begin
            err_code = hrhp_pkg::STAT_NOT_ALW;
          end else if (in_byte == hrhp_pkg::CH_CR) begin
            state_next = hrhp_pkg::ST_BLOCKEND;
          end else if (in_byte == hrhp_pkg::CH_LF) begin
            done = 1'b1;
          end else begin
            key_begin_next = pl;
            state_next     = hrhp_pkg::ST_HKEY;
          end
        end
        hrhp_pkg::ST_HKEY: begin
          if (in_byte == hrhp_pkg::CH_COLON) begin
            key_end_next = pl;
            state_next   = hrhp_pkg::ST_HVBEGIN;
          end else if (eol) begin
            key_end_next     = pl;
            value_begin_next = pl;
            value_end_next   = pl;
            if (in_byte == hrhp_pkg::CH_CR) begin
              state_next = hrhp_pkg::ST_HVFINAL;
            end else begin
              emit_kind  = hrhp_pkg::PK_HEADER;
              state_next = hrhp_pkg::ST_HREADY;
            end
          end
        end
        hrhp_pkg::ST_HVBEGIN: begin
          if (in_byte == hrhp_pkg::CH_SP) begin
            state_next = state;
          end else if (eol) begin
            value_begin_next = pl;
            value_end_next   = pl;
            if (in_byte == hrhp_pkg::CH_CR) begin
              state_next = hrhp_pkg::ST_HVFINAL;
            end else begin
              emit_kind  = hrhp_pkg::PK_HEADER;
              state_next = hrhp_pkg::ST_HREADY;
            end
          end else begin
            value_begin_next = pl;
            state_next       = hrhp_pkg::ST_HVAL;
          end
        end
        hrhp_pkg::ST_HVAL: begin
          if (in_byte == hrhp_pkg::CH_SP) begin
            value_end_next = pl;
            state_next     = hrhp_pkg::ST_HVSPACE;
          end else if (eol) begin
            value_end_next = pl;
            if (in_byte == hrhp_pkg::CH_CR) begin
              state_next = hrhp_pkg::ST_HVFINAL;
            end else begin
              emit_kind  = hrhp_pkg::PK_HEADER;
              state_next = hrhp_pkg::ST_HREADY;
            end
          end
        end
        hrhp_pkg::ST_HVSPACE: begin
          // a trailing blank run keeps the value end where it started
          if (in_byte == hrhp_pkg::CH_SP) begin
            state_next = state;
          end else if (in_byte == hrhp_pkg::CH_CR) begin
            state_next = hrhp_pkg::ST_HVFINAL;
          end else if (in_byte == hrhp_pkg::CH_LF) begin
            emit_kind  = hrhp_pkg::PK_HEADER;
            state_next = hrhp_pkg::ST_HREADY;
          end else begin
            state_next = hrhp_pkg::ST_HVAL;
          end
        end
        hrhp_pkg::ST_HVFINAL: begin
          if (in_byte == hrhp_pkg::CH_LF) begin
            emit_kind  = hrhp_pkg::PK_HEADER;
            state_next = hrhp_pkg::ST_HREADY;
          end else if (in_byte != hrhp_pkg::CH_CR) begin
            err_code = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_BLOCKEND: begin
          if (in_byte == hrhp_pkg::CH_LF) done = 1'b1;
          else err_code = hrhp_pkg::STAT_BAD;
        end
        default: begin
          err_code = hrhp_pkg::STAT_BAD;
        end
      endcase
    end
  end

  // result of the byte: status, finished pair and position bookkeeping
  always_comb begin
    stat_eff      = (sticky != hrhp_pkg::STAT_MORE) ? sticky : err_code;
    sticky_next   = stat_eff;
    position_next = position;
    state_fin     = state_next;
    vend          = emit_q ? pl : value_end_next;
    pks           = '0;
    pkl           = '0;
    pvs           = '0;
    pvl           = '0;
    if (stat_eff != hrhp_pkg::STAT_MORE) begin
      // errors are sticky, no pair is reported
      stat_res = stat_eff;
    end else if (done) begin
      stat_res      = hrhp_pkg::STAT_DONE;
      state_fin     = hrhp_pkg::ST_READY;
      position_next = '0;
    end else begin
      stat_res = hrhp_pkg::STAT_MORE;
      if (!skip) position_next = pos_t'(position + 1'b1);
      if (emit_kind != hrhp_pkg::PK_NONE) begin
        pks = key_begin;
        pkl = off_t'(key_end_next - key_begin);
        pvs = value_begin_next;
        pvl = off_t'(vend - value_begin_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hrhp_pkg::ST_READY;
      sticky       <= hrhp_pkg::STAT_MORE;
      method_q     <= hrhp_pkg::METH_NONE;
      version_q    <= hrhp_pkg::VER_09;
      position     <= '0;
      key_begin    <= '0;
      key_end      <= '0;
      value_begin  <= '0;
      value_end    <= '0;
      uri_begin    <= '0;
      uri_length   <= '0;
      query_length <= '0;
    end else if (advance) begin
      if (sticky_next == hrhp_pkg::STAT_MORE) state <= state_fin;
      sticky       <= sticky_next;
      method_q     <= method_next;
      version_q    <= version_next;
      position     <= position_next;
      key_begin    <= key_begin_next;
      key_end      <= key_end_next;
      value_begin  <= value_begin_next;
      value_end    <= value_end_next;
      uri_begin    <= uri_begin_next;
      uri_length   <= uri_length_next;
      query_length <= query_length_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tuser <= (stat_eff != hrhp_pkg::STAT_MORE || done) ? hrhp_pkg::PK_NONE : emit_kind;
      m_tdata <= {2'b00,
                  skip ? 16'd0 : o16(pl),
                  o16(query_length_next),
                  o16(uri_length_next),
                  o16(uri_begin_next),
                  version_next,
                  method_next,
                  o16(pvl),
                  o16(pvs),
                  o16(pkl),
                  o16(pks),
                  stat_res};
    end
  end

  // ---------------------------------------------------------------- assertions
  // once an error is latched it never changes until reset
  `HRHP_ASSERT_NEXT(a_sticky_holds, clk, rst, sticky != hrhp_pkg::STAT_MORE, $stable(sticky))
  // a finished request restarts the offsets
  `HRHP_ASSERT_NEXT(a_done_restarts, clk, rst, advance && stat_res == hrhp_pkg::STAT_DONE, position == '0)
  // a pair is only reported on a byte that parsed cleanly
  `HRHP_ASSERT_NOW(a_pair_clean, clk, rst, m_tvalid && m_tuser != hrhp_pkg::PK_NONE, m_tdata[1:0] == hrhp_pkg::STAT_MORE)

endmodule

// ----- tb/sv/http_request_head_parser_top_test.sv -----
// self-checking testbench for the http request head parser top level
`timescale 1ns / 100ps

module http_request_head_parser_top_test;

  localparam int          OFFSET_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 100000;  // many times a full run under every stall
  localparam int unsigned DRAIN_LIMIT = 5000;    // covers the long receiver hold-off
  localparam int unsigned IDLE_PCT    = 38;

  // character classes used when filling tokens with random content
  typedef enum int {
    TXT_TOKEN,
    TXT_PATH,
    TXT_ARG_KEY,
    TXT_ARG_VAL,
    TXT_HDR_KEY,
    TXT_HDR_VAL
  } text_class_t;

  // one parse result, field by field
  typedef struct packed {
    hrhp_pkg::status_t    status;
    hrhp_pkg::pair_kind_t kind;
    logic [15:0]          key_start;
    logic [15:0]          key_len;
    logic [15:0]          val_start;
    logic [15:0]          val_len;
    hrhp_pkg::method_t    method;
    hrhp_pkg::version_t   version;
    logic [15:0]          uri_start;
    logic [15:0]          uri_len;
    logic [15:0]          args_len;
    logic [15:0]          byte_offset;
  } parse_result_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [hrhp_pkg::TDATA_BITS-1:0] m_tdata;
  logic [1:0]                      m_tuser;

  http_request_head_parser_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // parser state as predicted, one step per accepted input transaction
  hrhp_pkg::state_t   hd_state   = hrhp_pkg::ST_READY;
  hrhp_pkg::status_t  hd_sticky  = hrhp_pkg::STAT_MORE;
  hrhp_pkg::method_t  hd_method  = hrhp_pkg::METH_NONE;
  hrhp_pkg::version_t hd_version = hrhp_pkg::VER_09;
  logic [16:0] hd_pos       = '0;  // one bit above the offset range to see an overrun
  logic [15:0] hd_key_begin = '0;
  logic [15:0] hd_key_end   = '0;
  logic [15:0] hd_val_begin = '0;
  logic [15:0] hd_val_end   = '0;
  logic [15:0] hd_uri_begin = '0;
  logic [15:0] hd_uri_len   = '0;
  logic [15:0] hd_query_len = '0;

  // pair finished by the current byte
  hrhp_pkg::pair_kind_t pr_kind;
  logic [15:0] pr_key_start;
  logic [15:0] pr_key_len;
  logic [15:0] pr_val_start;
  logic [15:0] pr_val_len;

  parse_result_t awaited_results[$];  // predicted results still to come out
  logic [7:0]    head_bytes[$];       // bytes of the request being assembled

  bit          gaps_on = 1'b1;
  int unsigned stall_req = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_done = 0;
  int unsigned query_pairs = 0;
  int unsigned header_pairs = 0;
  string       end_kind = "none";

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void close_pair(input hrhp_pkg::pair_kind_t k,
                                     input logic [15:0] vend);
    pr_kind      = k;
    pr_key_start = hd_key_begin;
    pr_key_len   = hd_key_end - hd_key_begin;
    pr_val_start = hd_val_begin;
    pr_val_len   = vend - hd_val_begin;
  endfunction

  // advances the predicted parser by one byte and returns the result it must give
  function automatic parse_result_t parse_step(input logic [7:0] ch);
    parse_result_t     r;
    hrhp_pkg::status_t st;
    hrhp_pkg::state_t  s;
    logic [16:0]       p;
    logic [15:0]       po;
    bit                done;
    bit                skip;
    bit                eol;
    st = hd_sticky;
    s = hd_state;
    p = hd_pos;
    po = p[15:0];
    done = 1'b0;
    skip = 1'b0;
    eol = (ch == hrhp_pkg::CH_CR) || (ch == hrhp_pkg::CH_LF);
    pr_kind = hrhp_pkg::PK_NONE;
    pr_key_start = '0;
    pr_key_len = '0;
    pr_val_start = '0;
    pr_val_len = '0;

    if (st == hrhp_pkg::STAT_MORE && s == hrhp_pkg::ST_READY && eol) begin
      // blank lines ahead of a request are dropped without using an offset
      skip = 1'b1;
    end else if (st == hrhp_pkg::STAT_MORE && p[16]) begin
      st = hrhp_pkg::STAT_BAD;
    end else if (st == hrhp_pkg::STAT_MORE) begin
      case (s)
        hrhp_pkg::ST_READY: begin
          if (ch == hrhp_pkg::CH_G || ch == hrhp_pkg::CH_H || ch == hrhp_pkg::CH_P) begin
            if (ch == hrhp_pkg::CH_G) hd_method = hrhp_pkg::METH_GET;
            else if (ch == hrhp_pkg::CH_H) hd_method = hrhp_pkg::METH_HEAD;
            else hd_method = hrhp_pkg::METH_POST;
            hd_version = hrhp_pkg::VER_09;
            hd_uri_begin = '0;
            hd_uri_len = '0;
            hd_query_len = '0;
            s = hrhp_pkg::ST_METHOD;
          end else begin
            st = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_METHOD: begin
          if (ch == hrhp_pkg::CH_SP) s = hrhp_pkg::ST_SPACES;
        end
        hrhp_pkg::ST_SPACES: begin
          if (ch == hrhp_pkg::CH_SLASH) begin
            hd_uri_begin = po;
            s = hrhp_pkg::ST_URI;
          end else if (ch != hrhp_pkg::CH_SP) begin
            st = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_URI, hrhp_pkg::ST_ARGS, hrhp_pkg::ST_ARGVAL: begin
          if (ch == hrhp_pkg::CH_SP || eol ||
              (s == hrhp_pkg::ST_URI && ch == hrhp_pkg::CH_QMARK)) begin
            if (s == hrhp_pkg::ST_URI) begin
              hd_uri_len = po - hd_uri_begin;
            end else begin
              if (s == hrhp_pkg::ST_ARGVAL) close_pair(hrhp_pkg::PK_QUERY, po);
              hd_query_len = po - (hd_uri_begin + hd_uri_len + 16'd1);
            end
            if (ch == hrhp_pkg::CH_QMARK) begin
              hd_key_begin = po + 16'd1;
              s = hrhp_pkg::ST_ARGS;
            end else if (ch == hrhp_pkg::CH_SP) begin
              s = hrhp_pkg::ST_PROT;
            end else begin
              hd_version = hrhp_pkg::VER_09;
              s = (ch == hrhp_pkg::CH_CR) ? hrhp_pkg::ST_LAST : hrhp_pkg::ST_HFIRST;
            end
          end else if (s != hrhp_pkg::ST_URI && ch == hrhp_pkg::CH_AMP) begin
            if (s == hrhp_pkg::ST_ARGVAL) close_pair(hrhp_pkg::PK_QUERY, po);
            hd_key_begin = po + 16'd1;
            s = hrhp_pkg::ST_ARGS;
          end else if (s == hrhp_pkg::ST_ARGS && ch == hrhp_pkg::CH_EQ) begin
            hd_key_end = po;
            hd_val_begin = po + 16'd1;
            s = hrhp_pkg::ST_ARGVAL;
          end
        end
        hrhp_pkg::ST_PROT: begin
          if (ch != hrhp_pkg::CH_SP) begin
            if (eol) begin
              hd_version = hrhp_pkg::VER_09;
              s = (ch == hrhp_pkg::CH_CR) ? hrhp_pkg::ST_LAST : hrhp_pkg::ST_HFIRST;
            end else if (ch == hrhp_pkg::CH_H) begin
              s = hrhp_pkg::ST_P_H;
            end else begin
              st = hrhp_pkg::STAT_BAD;
            end
          end
        end
        hrhp_pkg::ST_P_H: begin
          if (ch == hrhp_pkg::CH_T) s = hrhp_pkg::ST_P_HT;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HT: begin
          if (ch == hrhp_pkg::CH_T) s = hrhp_pkg::ST_P_HTT;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HTT: begin
          if (ch == hrhp_pkg::CH_P) s = hrhp_pkg::ST_P_HTTP;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_P_HTTP: begin
          if (ch == hrhp_pkg::CH_SLASH) s = hrhp_pkg::ST_MAJOR;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_MAJOR: begin
          if (ch == hrhp_pkg::CH_DOT) s = hrhp_pkg::ST_MINOR;
          else if (ch == hrhp_pkg::CH_0) hd_version = hrhp_pkg::VER_09;
          else if (ch == hrhp_pkg::CH_1) hd_version = hrhp_pkg::VER_10;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_MINOR, hrhp_pkg::ST_PFINAL: begin
          if (ch == hrhp_pkg::CH_SP) s = hrhp_pkg::ST_PFINAL;
          else if (ch == hrhp_pkg::CH_CR) s = hrhp_pkg::ST_LAST;
          else if (ch == hrhp_pkg::CH_LF) s = hrhp_pkg::ST_HFIRST;
          else if (s == hrhp_pkg::ST_MINOR && ch == hrhp_pkg::CH_0)
            hd_version = hrhp_pkg::VER_10;
          else if (s == hrhp_pkg::ST_MINOR && ch == hrhp_pkg::CH_1)
            hd_version = hrhp_pkg::VER_11;
          else if (s == hrhp_pkg::ST_MINOR && ch == hrhp_pkg::CH_9)
            hd_version = hrhp_pkg::VER_09;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_LAST: begin
          if (ch == hrhp_pkg::CH_LF) s = hrhp_pkg::ST_HFIRST;
          else st = hrhp_pkg::STAT_BAD;
        end
        hrhp_pkg::ST_HFIRST, hrhp_pkg::ST_HREADY: begin
          if (s == hrhp_pkg::ST_HFIRST && hd_version == hrhp_pkg::VER_09 &&
              hd_method != hrhp_pkg::METH_GET) begin
            st = hrhp_pkg::STAT_NOT_ALW;
          end else if (ch == hrhp_pkg::CH_CR) begin
            s = hrhp_pkg::ST_BLOCKEND;
          end else if (ch == hrhp_pkg::CH_LF) begin
            done = 1'b1;
          end else begin
            hd_key_begin = po;
            s = hrhp_pkg::ST_HKEY;
          end
        end
        hrhp_pkg::ST_HKEY: begin
          if (ch == hrhp_pkg::CH_COLON) begin
            hd_key_end = po;
            s = hrhp_pkg::ST_HVBEGIN;
          end else if (eol) begin
            hd_key_end = po;
            hd_val_begin = po;
            hd_val_end = po;
            if (ch == hrhp_pkg::CH_CR) begin
              s = hrhp_pkg::ST_HVFINAL;
            end else begin
              close_pair(hrhp_pkg::PK_HEADER, hd_val_end);
              s = hrhp_pkg::ST_HREADY;
            end
          end
        end
        hrhp_pkg::ST_HVBEGIN: begin
          if (ch != hrhp_pkg::CH_SP) begin
            hd_val_begin = po;
            if (eol) begin
              hd_val_end = po;
              if (ch == hrhp_pkg::CH_CR) begin
                s = hrhp_pkg::ST_HVFINAL;
              end else begin
                close_pair(hrhp_pkg::PK_HEADER, hd_val_end);
                s = hrhp_pkg::ST_HREADY;
              end
            end else begin
              s = hrhp_pkg::ST_HVAL;
            end
          end
        end
        hrhp_pkg::ST_HVAL: begin
          if (ch == hrhp_pkg::CH_SP) begin
            hd_val_end = po;
            s = hrhp_pkg::ST_HVSPACE;
          end else if (eol) begin
            hd_val_end = po;
            if (ch == hrhp_pkg::CH_CR) begin
              s = hrhp_pkg::ST_HVFINAL;
            end else begin
              close_pair(hrhp_pkg::PK_HEADER, hd_val_end);
              s = hrhp_pkg::ST_HREADY;
            end
          end
        end
        hrhp_pkg::ST_HVSPACE: begin
          // value end stays at the first blank of a trailing run
          if (ch == hrhp_pkg::CH_CR) begin
            s = hrhp_pkg::ST_HVFINAL;
          end else if (ch == hrhp_pkg::CH_LF) begin
            close_pair(hrhp_pkg::PK_HEADER, hd_val_end);
            s = hrhp_pkg::ST_HREADY;
          end else if (ch != hrhp_pkg::CH_SP) begin
            s = hrhp_pkg::ST_HVAL;
          end
        end
        hrhp_pkg::ST_HVFINAL: begin
          if (ch == hrhp_pkg::CH_LF) begin
            close_pair(hrhp_pkg::PK_HEADER, hd_val_end);
            s = hrhp_pkg::ST_HREADY;
          end else if (ch != hrhp_pkg::CH_CR) begin
            st = hrhp_pkg::STAT_BAD;
          end
        end
        hrhp_pkg::ST_BLOCKEND: begin
          if (ch == hrhp_pkg::CH_LF) done = 1'b1;
          else st = hrhp_pkg::STAT_BAD;
        end
        default: st = hrhp_pkg::STAT_BAD;
      endcase
    end

    if (st != hrhp_pkg::STAT_MORE) begin
      // error answers stick until reset and carry no pair
      pr_kind = hrhp_pkg::PK_NONE;
      pr_key_start = '0;
      pr_key_len = '0;
      pr_val_start = '0;
      pr_val_len = '0;
      if (hd_sticky == hrhp_pkg::STAT_MORE) hd_sticky = st;
      st = hd_sticky;
    end else if (done) begin
      st = hrhp_pkg::STAT_DONE;
      s = hrhp_pkg::ST_READY;
      hd_pos = '0;
      requests_done++;
    end else if (!skip) begin
      hd_pos = p + 17'd1;
    end
    if (hd_sticky == hrhp_pkg::STAT_MORE) hd_state = s;
    if (pr_kind == hrhp_pkg::PK_QUERY) query_pairs++;
    if (pr_kind == hrhp_pkg::PK_HEADER) header_pairs++;

    r.status      = st;
    r.kind        = pr_kind;
    r.key_start   = pr_key_start;
    r.key_len     = pr_key_len;
    r.val_start   = pr_val_start;
    r.val_len     = pr_val_len;
    r.method      = hd_method;
    r.version     = hd_version;
    r.uri_start   = hd_uri_begin;
    r.uri_len     = hd_uri_len;
    r.args_len    = hd_query_len;
    r.byte_offset = skip ? 16'd0 : po;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request assembly
  // ---------------------------------------------------------------------------

  // random byte, mostly printable, never one that would end the current token
  function automatic logic [7:0] text_byte(input text_class_t cls);
    logic [7:0] b;
    bit         ok;
    ok = 1'b0;
    b = '0;
    while (!ok) begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(126, 33));
      case (cls)
        TXT_TOKEN:   ok = (b != hrhp_pkg::CH_SP);
        TXT_PATH:    ok = (b != hrhp_pkg::CH_SP) && (b != hrhp_pkg::CH_CR) &&
                          (b != hrhp_pkg::CH_LF) && (b != hrhp_pkg::CH_QMARK);
        TXT_ARG_KEY: ok = (b != hrhp_pkg::CH_SP) && (b != hrhp_pkg::CH_CR) &&
                          (b != hrhp_pkg::CH_LF) && (b != hrhp_pkg::CH_AMP) &&
                          (b != hrhp_pkg::CH_EQ);
        TXT_ARG_VAL: ok = (b != hrhp_pkg::CH_SP) && (b != hrhp_pkg::CH_CR) &&
                          (b != hrhp_pkg::CH_LF) && (b != hrhp_pkg::CH_AMP);
        TXT_HDR_KEY: ok = (b != hrhp_pkg::CH_CR) && (b != hrhp_pkg::CH_LF) &&
                          (b != hrhp_pkg::CH_COLON);
        default:     ok = (b != hrhp_pkg::CH_CR) && (b != hrhp_pkg::CH_LF);
      endcase
    end
    return b;
  endfunction

  // line end: lf, cr lf, or cr cr lf where a header line allows it
  task automatic push_eol(input bit allow_cr_cr);
    int unsigned pick;
    pick = $urandom_range(2);
    if (pick != 0) head_bytes.push_back(hrhp_pkg::CH_CR);
    if (pick == 2 && allow_cr_cr) head_bytes.push_back(hrhp_pkg::CH_CR);
    head_bytes.push_back(hrhp_pkg::CH_LF);
  endtask

  // well-formed request with random content; a method other than get always
  // carries a version so that it is never refused
  task automatic build_request();
    logic [7:0]  m;
    int unsigned i;
    int unsigned n;
    int unsigned form;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1))
        head_bytes.push_back($urandom_range(1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF);
    case ($urandom_range(2))
      0: m = hrhp_pkg::CH_G;
      1: m = hrhp_pkg::CH_H;
      default: m = hrhp_pkg::CH_P;
    endcase
    head_bytes.push_back(m);
    repeat ($urandom_range(4)) head_bytes.push_back(text_byte(TXT_TOKEN));
    repeat ($urandom_range(2, 1)) head_bytes.push_back(hrhp_pkg::CH_SP);
    head_bytes.push_back(hrhp_pkg::CH_SLASH);
    repeat ($urandom_range(8)) head_bytes.push_back(text_byte(TXT_PATH));
    if ($urandom_range(1)) begin
      head_bytes.push_back(hrhp_pkg::CH_QMARK);
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) begin
        if (i != 0) head_bytes.push_back(hrhp_pkg::CH_AMP);
        repeat ($urandom_range(4)) head_bytes.push_back(text_byte(TXT_ARG_KEY));
        if ($urandom_range(2) != 0) begin
          head_bytes.push_back(hrhp_pkg::CH_EQ);
          repeat ($urandom_range(5)) head_bytes.push_back(text_byte(TXT_ARG_VAL));
        end
      end
    end
    form = (m == hrhp_pkg::CH_G) ? $urandom_range(2) : 2;
    if (form != 0) repeat ($urandom_range(2, 1)) head_bytes.push_back(hrhp_pkg::CH_SP);
    if (form == 2) begin
      head_bytes.push_back(hrhp_pkg::CH_H);
      head_bytes.push_back(hrhp_pkg::CH_T);
      head_bytes.push_back(hrhp_pkg::CH_T);
      head_bytes.push_back(hrhp_pkg::CH_P);
      head_bytes.push_back(hrhp_pkg::CH_SLASH);
      repeat ($urandom_range(2))
        head_bytes.push_back($urandom_range(1) ? hrhp_pkg::CH_1 : hrhp_pkg::CH_0);
      head_bytes.push_back(hrhp_pkg::CH_DOT);
      n = (m == hrhp_pkg::CH_G) ? $urandom_range(2) : $urandom_range(2, 1);
      for (i = 0; i < n; i++) begin
        if (m != hrhp_pkg::CH_G)
          head_bytes.push_back($urandom_range(1) ? hrhp_pkg::CH_1 : hrhp_pkg::CH_0);
        else if ($urandom_range(2) == 0)
          head_bytes.push_back(hrhp_pkg::CH_9);
        else
          head_bytes.push_back($urandom_range(1) ? hrhp_pkg::CH_1 : hrhp_pkg::CH_0);
      end
      repeat ($urandom_range(2)) head_bytes.push_back(hrhp_pkg::CH_SP);
    end
    push_eol(1'b0);
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(6, 1)) head_bytes.push_back(text_byte(TXT_HDR_KEY));
      if ($urandom_range(4) != 0) begin
        head_bytes.push_back(hrhp_pkg::CH_COLON);
        repeat ($urandom_range(2)) head_bytes.push_back(hrhp_pkg::CH_SP);
        repeat ($urandom_range(6)) head_bytes.push_back(text_byte(TXT_HDR_VAL));
        repeat ($urandom_range(2)) head_bytes.push_back(hrhp_pkg::CH_SP);
      end
      push_eol(1'b1);
    end
    push_eol(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // input side: one byte per transaction, driven at the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_results.push_back(parse_step(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (head_bytes.size() != 0) send_byte(head_bytes.pop_front());
  endtask

  // sender stops until every predicted result has come out or the drain limit is reached, then idles
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $display("%0d results never came out", awaited_results.size());
      fault_count++;
      awaited_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: ready driven at the falling edge, long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : ready_driver
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != 0) begin
        stall_left = stall_req;
        stall_req = 0;
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= !(gaps_on && ($urandom_range(99) < IDLE_PCT));
      end
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (fault_count < 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
      fault_count++;
    end
  endtask

  // every output transaction is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        if (fault_count < 10) $display("result %0d arrived with none predicted", results_seen);
        fault_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 16'(want.status), 16'(m_tdata[1:0]));
        check_field("pair_kind", 16'(want.kind), 16'(m_tuser));
        check_field("key_start", want.key_start, m_tdata[17:2]);
        check_field("key_len", want.key_len, m_tdata[33:18]);
        check_field("val_start", want.val_start, m_tdata[49:34]);
        check_field("val_len", want.val_len, m_tdata[65:50]);
        check_field("method_code", 16'(want.method), 16'(m_tdata[67:66]));
        check_field("version_code", 16'(want.version), 16'(m_tdata[69:68]));
        check_field("uri_start", want.uri_start, m_tdata[85:70]);
        check_field("uri_len", want.uri_len, m_tdata[101:86]);
        check_field("args_len", want.args_len, m_tdata[117:102]);
        check_field("byte_offset", want.byte_offset, m_tdata[133:118]);
      end
      results_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("[http_request_head_parser_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // blank lines, post with binary token byte, query pairs with extreme bytes,
  // version 1.1, a header with a trailing blank, then a bare get
  task automatic test_directed_head();
    head_bytes = '{hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, hrhp_pkg::CH_P, 8'h00,
                   hrhp_pkg::CH_SP, hrhp_pkg::CH_SLASH, hrhp_pkg::CH_QMARK, 8'h61,
                   hrhp_pkg::CH_EQ, 8'hFF, hrhp_pkg::CH_AMP, 8'h62, hrhp_pkg::CH_SP,
                   hrhp_pkg::CH_H, hrhp_pkg::CH_T, hrhp_pkg::CH_T, hrhp_pkg::CH_P,
                   hrhp_pkg::CH_SLASH, hrhp_pkg::CH_1, hrhp_pkg::CH_DOT, hrhp_pkg::CH_1,
                   hrhp_pkg::CH_LF, 8'h6B, hrhp_pkg::CH_COLON, hrhp_pkg::CH_SP, 8'h76,
                   hrhp_pkg::CH_SP, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, hrhp_pkg::CH_LF,
                   hrhp_pkg::CH_G, hrhp_pkg::CH_SP, hrhp_pkg::CH_SLASH, hrhp_pkg::CH_LF,
                   hrhp_pkg::CH_LF};
    send_queued();
    wait_for_results();
  endtask

  task automatic test_random_requests(input int unsigned byte_goal);
    int unsigned stop_at;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      build_request();
      send_queued();
    end
  endtask

  // both sides run flat out, no idling anywhere
  task automatic test_steady_stream();
    gaps_on = 1'b0;
    test_random_requests(300);
    gaps_on = 1'b1;
  endtask

  // receiver holds off long enough for the parser to back up into its input
  task automatic test_receiver_hold();
    stall_req = 300;
    test_random_requests(80);
    wait_for_results();
  endtask

  // single requests with the sender idle until each has fully drained
  task automatic test_drained_pauses();
    repeat (4) begin
      build_request();
      send_queued();
      wait_for_results();
    end
  endtask

  // error answers stick until reset, so exactly one of them closes the run
  task automatic test_error_answer();
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  tail[$];
    pick = $urandom_range(9);
    if (pick < 6) begin
      end_kind = "bad request";
      build_request();
      case ($urandom_range(2))
        0: begin
          // first byte of the next request is not a method letter
          do b = 8'($urandom_range(255));
          while (b == hrhp_pkg::CH_G || b == hrhp_pkg::CH_H || b == hrhp_pkg::CH_P ||
                 b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF);
          head_bytes.push_back(b);
        end
        1: begin
          // bad digit in the version
          tail = '{hrhp_pkg::CH_G, hrhp_pkg::CH_SP, hrhp_pkg::CH_SLASH, hrhp_pkg::CH_SP,
                   hrhp_pkg::CH_H, hrhp_pkg::CH_T, hrhp_pkg::CH_T, hrhp_pkg::CH_P,
                   hrhp_pkg::CH_SLASH};
          foreach (tail[i]) head_bytes.push_back(tail[i]);
          do b = 8'($urandom_range(255));
          while (b == hrhp_pkg::CH_DOT || b == hrhp_pkg::CH_0 || b == hrhp_pkg::CH_1);
          head_bytes.push_back(b);
        end
        default: begin
          // carriage return ending the header block not followed by a line feed
          tail = '{hrhp_pkg::CH_G, hrhp_pkg::CH_SP, hrhp_pkg::CH_SLASH, hrhp_pkg::CH_LF,
                   hrhp_pkg::CH_CR};
          foreach (tail[i]) head_bytes.push_back(tail[i]);
          do b = 8'($urandom_range(255));
          while (b == hrhp_pkg::CH_LF);
          head_bytes.push_back(b);
        end
      endcase
    end else begin
      // head or post without a version is refused on the next byte
      end_kind = "not allowed";
      head_bytes.push_back($urandom_range(1) ? hrhp_pkg::CH_H : hrhp_pkg::CH_P);
      repeat ($urandom_range(3)) head_bytes.push_back(text_byte(TXT_TOKEN));
      head_bytes.push_back(hrhp_pkg::CH_SP);
      head_bytes.push_back(hrhp_pkg::CH_SLASH);
      repeat ($urandom_range(5)) head_bytes.push_back(text_byte(TXT_PATH));
      push_eol(1'b0);
      head_bytes.push_back(8'($urandom_range(255)));
    end
    send_queued();
    // everything after the error must keep the same answer
    repeat (32) head_bytes.push_back(8'($urandom_range(255)));
    send_queued();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_head();
    test_random_requests(650);
    wait_for_results();
    test_steady_stream();
    test_receiver_hold();
    test_drained_pauses();
    test_random_requests(300);
    test_error_answer();
    wait_for_results();
    repeat (4) @(posedge clk);

    $display("covered %0d bytes in %0d results: %0d requests finished,", bytes_sent,
             results_seen, requests_done);
    $display("%0d query pairs, %0d header pairs, run closed on a %s answer, %0d faults",
             query_pairs, header_pairs, end_kind, fault_count);
    if (fault_count == 0) begin
      $display("[http_request_head_parser_top] OK");
    end else begin
      $display("[http_request_head_parser_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- http_request_head_parser_top.f -----
+incdir+hw/rtl
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_head_parser_top.sv
tb/sv/http_request_head_parser_top_test.sv
